// ===== src/bad_block_skip_translator_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the bad block skip translator
// Concurrent checks sampled on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef BAD_BLOCK_SKIP_TRANSLATOR_TOP_MACROS_SVH
`define BAD_BLOCK_SKIP_TRANSLATOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define BBST_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Condition must never be seen outside reset.
`define BBST_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define BBST_ASSERT(lbl, prop, msg)
`define BBST_NEVER(lbl, cond, msg)
`endif
`endif

// ===== src/bbst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbst_pkg
// Types and constants shared by the bad block skip translator modules.
// ----------------------------------------------------------------------------
package bbst_pkg;

	// Default table depth in erase blocks.
	localparam int DEF_MAX_BLOCKS = 4096;

	// Fixed field widths.
	localparam int CNT_W      = 13;
	localparam int SHIFT_W    = 5;
	localparam int SECTOR_W   = 32;
	localparam int ADDR_W     = 32;
	localparam int CFG_DATA_W = 13;
	localparam int CFG_IDX_W  = 2;

	// Sector size and erase shift limits.
	localparam int SECTOR_LOG2 = 9;
	localparam logic [SHIFT_W-1:0] SHIFT_MIN = 5'd9;
	localparam logic [SHIFT_W-1:0] SHIFT_MAX = 5'd20;

	// Register indexes and reset values.
	localparam logic [CFG_IDX_W-1:0] REG_ERASE_SHIFT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TOTAL_BLOCKS = 2'd1;
	localparam logic [SHIFT_W-1:0]   ERASE_SHIFT_RST  = 5'd17;
	localparam logic [CNT_W-1:0]     TOTAL_BLOCKS_RST = 13'd4096;

	// Operation codes.
	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_WRITE = 2'd2;

	// Status codes.
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BEYOND    = 2'd1;
	localparam logic [1:0] ST_READ_ONLY = 2'd2;
	localparam logic [1:0] ST_LOAD_FULL = 2'd3;

	// Input request.
	typedef struct packed {
		logic [1:0]          op;
		logic                bad_flag;
		logic [SECTOR_W-1:0] sector;
	} req_t;

	// Result.
	typedef struct packed {
		logic [1:0]        status;
		logic [ADDR_W-1:0] flash_addr;
		logic [CNT_W-1:0]  good_count;
		logic [CNT_W-1:0]  bad_count;
	} rsp_t;

	// Request state handed from the lookup stage to the response stage.
	typedef struct packed {
		logic                valid;
		logic                map_ok;
		logic [1:0]          status;
		logic [SECTOR_W-1:0] sector;
		logic [SHIFT_W-1:0]  shift;
		logic [CNT_W-1:0]    good;
		logic [CNT_W-1:0]    bad;
	} stage_t;

endpackage

// ===== src/bbst_table_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbst_table_ram
// Logical to physical block map: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bbst_table_ram #(
	parameter int DEPTH  = 4096,
	parameter int AW     = $clog2(DEPTH),
	parameter int DW     = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	// Write and read; the read data is registered.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/bbst_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbst_ctrl
// Request decode, block counters, map write on load and map read on translate.
// ----------------------------------------------------------------------------
`include "bad_block_skip_translator_top_macros.svh"
module bbst_ctrl import bbst_pkg::*; #(
	parameter int MAX_BLOCKS = DEF_MAX_BLOCKS,
	parameter int IDX_W      = $clog2(MAX_BLOCKS)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  req_t               req,
	input  logic [SHIFT_W-1:0] erase_shift,
	input  logic [CNT_W-1:0]   total_blocks,
	output logic               tbl_we,
	output logic [IDX_W-1:0]   tbl_waddr,
	output logic [IDX_W-1:0]   tbl_wdata,
	output logic               tbl_re,
	output logic [IDX_W-1:0]   tbl_raddr,
	output stage_t             stage
);

	logic [CNT_W-1:0]    good_q, bad_q, phys_q;
	logic [CNT_W-1:0]    good_d, bad_d, phys_d;
	logic [SHIFT_W-1:0]  shift;
	logic [SHIFT_W-1:0]  blk_shift;
	logic [SECTOR_W-1:0] blk;
	logic [31:0]         good_ext, phys_ext;
	logic                full, beyond, is_load, is_read;
	logic [1:0]          status;
	stage_t              stage_s1;

	// Erase shift clamped to the supported range.
	always_comb begin
		if (erase_shift < SHIFT_MIN) begin
			shift = SHIFT_MIN;
		end else if (erase_shift > SHIFT_MAX) begin
			shift = SHIFT_MAX;
		end else begin
			shift = erase_shift;
		end
	end

	assign good_ext = 32'(good_q);
	assign phys_ext = 32'(phys_q);
	assign is_load  = (req.op == OP_LOAD);
	assign is_read  = (req.op == OP_READ);

	// A load is refused once the physical position reaches the clamped total.
	assign full = (phys_q >= total_blocks) || (phys_ext >= 32'(MAX_BLOCKS));

	// Logical block of the sector, and its range check.
	assign blk_shift = shift - SHIFT_MIN;
	assign blk       = req.sector >> blk_shift;
	assign beyond    = (blk >= good_ext) || (blk >= 32'(MAX_BLOCKS));

	// Status and counter updates.
	always_comb begin
		good_d = good_q;
		bad_d  = bad_q;
		phys_d = phys_q;
		case (req.op)
			OP_LOAD: begin
				status = full ? ST_LOAD_FULL : ST_OK;
				if (!full) begin
					phys_d = phys_q + 1'b1;
					if (req.bad_flag) begin
						bad_d = bad_q + 1'b1;
					end else begin
						good_d = good_q + 1'b1;
					end
				end
			end
			OP_READ: begin
				status = beyond ? ST_BEYOND : ST_OK;
			end
			default: begin
				status = ST_READ_ONLY;
			end
		endcase
	end

	// Map port requests.
	assign tbl_we    = accept && is_load && !full && !req.bad_flag &&
	                   (good_ext < 32'(MAX_BLOCKS));
	assign tbl_waddr = good_ext[IDX_W-1:0];
	assign tbl_wdata = phys_ext[IDX_W-1:0];
	assign tbl_re    = accept && is_read && !beyond;
	assign tbl_raddr = blk[IDX_W-1:0];

	// Counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			good_q <= '0;
			bad_q  <= '0;
			phys_q <= '0;
		end else if (accept) begin
			good_q <= good_d;
			bad_q  <= bad_d;
			phys_q <= phys_d;
		end
	end

	// Stage register towards the response stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_s1 <= '0;
		end else begin
			stage_s1.valid <= accept;
			if (accept) begin
				stage_s1.map_ok <= is_read && !beyond;
				stage_s1.status <= status;
				stage_s1.sector <= req.sector;
				stage_s1.shift  <= shift;
				stage_s1.good   <= good_d;
				stage_s1.bad    <= bad_d;
			end
		end
	end

	assign stage = stage_s1;

	// Every accepted load counts as either good or bad.
	`BBST_ASSERT(a_count_sum, (14'(good_q) + 14'(bad_q)) == 14'(phys_q), "good plus bad differs from position")
	// A load that is taken advances the position by one.
	`BBST_ASSERT(a_load_step, (accept && is_load && !full) |=> (phys_q == $past(phys_q) + 1'b1), "load did not advance position")
	// The map is never read and written in the same cycle.
	`BBST_NEVER(a_port_clash, tbl_we && tbl_re, "map read and write together")

endmodule

// ===== src/bbst_resp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbst_resp
// Builds the flash byte address from the map entry and registers the result.
// ----------------------------------------------------------------------------
module bbst_resp import bbst_pkg::*; #(
	parameter int IDX_W = $clog2(DEF_MAX_BLOCKS)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  stage_t           stage,
	input  logic [IDX_W-1:0] entry,
	output logic             done,
	output rsp_t             rsp
);

	logic [ADDR_W-1:0] base, offs, mask, byte_addr;
	logic              done_s2;
	rsp_t              rsp_s2;

	// Physical block shifted into place, ORed with the offset within the block.
	assign byte_addr = {stage.sector[ADDR_W-SECTOR_LOG2-1:0], {SECTOR_LOG2{1'b0}}};
	assign mask      = (ADDR_W'(1) << stage.shift) - 1'b1;
	assign offs      = byte_addr & mask;
	assign base      = ADDR_W'(entry) << stage.shift;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= stage.valid;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (stage.valid) begin
			rsp_s2.status     <= stage.status;
			rsp_s2.flash_addr <= stage.map_ok ? (base | offs) : '0;
			rsp_s2.good_count <= stage.good;
			rsp_s2.bad_count  <= stage.bad;
		end
	end

	assign done = done_s2;
	assign rsp  = rsp_s2;

endmodule

// ===== src/bad_block_skip_translator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bad_block_skip_translator_top
// Maps logical erase blocks onto good physical blocks and translates sectors.
// ----------------------------------------------------------------------------
// A request is taken whenever start is high; busy is never raised, so one
// request may follow another in every cycle. Each request gives one result,
// shown with done for a single cycle, in the order taken, once it has passed
// the stage register (with the map's registered read port) and the result
// register. The receiver cannot hold results off, so it must take each one
// as it appears. The map is not cleared after reset: translations only reach
// entries already loaded. Registers are written through cfg_we, cfg_index and
// cfg_data; the user must do so only while idle; the block does not check.
`include "bad_block_skip_translator_top_macros.svh"
module bad_block_skip_translator_top import bbst_pkg::*; #(
	parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  req_t                  req,
	output logic                  done,
	output rsp_t                  rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int IDX_W = $clog2(MAX_BLOCKS);

	logic [SHIFT_W-1:0] erase_shift_q;
	logic [CNT_W-1:0]   total_blocks_q;
	logic               accept;
	logic               tbl_we, tbl_re;
	logic [IDX_W-1:0]   tbl_waddr, tbl_wdata, tbl_raddr, tbl_rdata;
	stage_t             stage;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			erase_shift_q  <= ERASE_SHIFT_RST;
			total_blocks_q <= TOTAL_BLOCKS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ERASE_SHIFT:  erase_shift_q  <= cfg_data[SHIFT_W-1:0];
				REG_TOTAL_BLOCKS: total_blocks_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	bbst_ctrl #(
		.MAX_BLOCKS (MAX_BLOCKS),
		.IDX_W      (IDX_W)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.req          (req),
		.erase_shift  (erase_shift_q),
		.total_blocks (total_blocks_q),
		.tbl_we       (tbl_we),
		.tbl_waddr    (tbl_waddr),
		.tbl_wdata    (tbl_wdata),
		.tbl_re       (tbl_re),
		.tbl_raddr    (tbl_raddr),
		.stage        (stage)
	);

	bbst_table_ram #(
		.DEPTH (MAX_BLOCKS),
		.AW    (IDX_W),
		.DW    (IDX_W)
	) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.re    (tbl_re),
		.raddr (tbl_raddr),
		.rdata (tbl_rdata)
	);

	bbst_resp #(
		.IDX_W (IDX_W)
	) u_resp (
		.clk    (clk),
		.arst_n (arst_n),
		.stage  (stage),
		.entry  (tbl_rdata),
		.done   (done),
		.rsp    (rsp)
	);

	// Every request taken gives a result after the stage and result registers.
	`BBST_ASSERT(a_req_to_done, accept |-> ##2 done, "result missing after request")
	// No result appears without an earlier request.
	`BBST_ASSERT(a_done_has_req, done |-> $past(accept, 2), "result without request")

endmodule
